// File: sv/cantxq_pkg.sv
// Shared types and constants for the CAN transmit message queue.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package cantxq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int ID_W   = 29;
    localparam int LEN_W  = 4;
    localparam int DATA_W = 64;

    localparam logic [LEN_W-1:0] MAX_LEN = 4'd8;

    // request codes
    localparam logic REQ_ENQUEUE = 1'b0;
    localparam logic REQ_TX_DONE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADLEN = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_EXEC,
        CS_LOAD
    } ctrl_state_t;

    // one stored frame
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: sv/cantxq_ctrl.sv
// Sequencer for the CAN transmit queue: capture, execute, load result.
// Depends on cantxq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cantxq_ctrl (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  cantxq_pkg::dp_stat_t  stat,
    output cantxq_pkg::dp_cmd_t   cmd
);

    cantxq_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cantxq_pkg::CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd         = '0;
        case (state_reg)
            cantxq_pkg::CS_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = cantxq_pkg::CS_EXEC;
                end
            end
            cantxq_pkg::CS_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = cantxq_pkg::CS_LOAD;
            end
            cantxq_pkg::CS_LOAD: begin
                // hold until the output register can take the beat
                if (stat.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = cantxq_pkg::CS_IDLE;
                end
            end
            default: begin
                state_next = cantxq_pkg::CS_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/cantxq_dp.sv
// Datapath of the CAN transmit queue: frame memory, ring pointers,
// identifier packing and the output register. Depends on cantxq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cantxq_dp #(
    parameter int QUEUE_DEPTH = cantxq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  cantxq_pkg::dp_cmd_t                  cmd,
    output cantxq_pkg::dp_stat_t                 stat,
    input  wire                                  cfg_we,
    input  wire                                  cfg_data,
    input  wire                                  s_req_type,
    input  wire [cantxq_pkg::ID_W-1:0]           s_frame_id,
    input  wire [cantxq_pkg::LEN_W-1:0]          s_frame_length,
    input  wire [cantxq_pkg::DATA_W-1:0]         s_frame_data,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic [1:0]                           m_status,
    output logic                                 m_launch,
    output logic [7:0]                           m_id_byte1,
    output logic [7:0]                           m_id_byte2,
    output logic [7:0]                           m_id_byte3,
    output logic [7:0]                           m_id_byte4,
    output logic [cantxq_pkg::LEN_W-1:0]         m_tx_length,
    output logic [cantxq_pkg::DATA_W-1:0]        m_tx_data,
    output logic                                 m_busy_res
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);

    // configuration
    logic ext_mode_reg;

    // captured request
    logic                          req_reg;
    cantxq_pkg::entry_t            in_reg;

    // queue state
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic             wrap_reg, wrap_next;
    logic             sending_reg, sending_next;

    // per-item decision, held for the load step
    cantxq_pkg::status_t status_reg, status_next;
    logic                launch_reg, launch_next;
    logic                bypass_reg, bypass_next;
    logic                wr_en;

    cantxq_pkg::entry_t queue_mem_reg [QUEUE_DEPTH];
    cantxq_pkg::entry_t rd_entry_reg;

    // output register
    logic                            m_valid_reg;
    cantxq_pkg::status_t             m_status_reg;
    logic                            m_launch_reg;
    logic [7:0]                      m_b1_reg, m_b2_reg, m_b3_reg, m_b4_reg;
    logic [cantxq_pkg::LEN_W-1:0]    m_len_reg;
    logic [cantxq_pkg::DATA_W-1:0]   m_data_reg;
    logic                            m_busy_reg;

    cantxq_pkg::entry_t              head_ent;
    logic [7:0]                      b1, b2, b3, b4;
    logic [cantxq_pkg::DATA_W-1:0]   masked_data;

    function automatic logic [PTR_W-1:0] next_idx(input logic [PTR_W-1:0] p);
        next_idx = (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            ext_mode_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg     <= s_req_type;
            in_reg.id   <= s_frame_id;
            in_reg.len  <= s_frame_length;
            in_reg.data <= s_frame_data;
        end
    end

    // ring update for one request
    always_comb begin
        logic full, empty, do_launch;
        full         = (head_reg == tail_reg) && wrap_reg;
        empty        = (head_reg == tail_reg) && !wrap_reg;
        do_launch    = 1'b0;
        wr_en        = 1'b0;
        status_next  = cantxq_pkg::ST_OK;
        head_next    = head_reg;
        tail_next    = tail_reg;
        wrap_next    = wrap_reg;
        sending_next = sending_reg;
        if (req_reg == cantxq_pkg::REQ_ENQUEUE) begin
            if (full) begin
                status_next = cantxq_pkg::ST_FULL;
            end else if (in_reg.len > cantxq_pkg::MAX_LEN) begin
                status_next = cantxq_pkg::ST_BADLEN;
            end else begin
                wr_en     = 1'b1;
                tail_next = next_idx(tail_reg);
                if (tail_next == '0) begin
                    wrap_next = 1'b1;
                end
                do_launch = !sending_reg;
            end
        end else begin
            if (empty) begin
                sending_next = 1'b0;
            end else begin
                do_launch = 1'b1;
            end
        end
        if (do_launch) begin
            head_next    = next_idx(head_reg);
            sending_next = 1'b1;
            if (head_next == '0) begin
                wrap_next = 1'b0;
            end
        end
        launch_next = do_launch;
        // frame written this step is also the head: take it from the input
        bypass_next = do_launch && wr_en && (head_reg == tail_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            wrap_reg    <= 1'b0;
            sending_reg <= 1'b0;
        end else if (cmd.exec) begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            wrap_reg    <= wrap_next;
            sending_reg <= sending_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg <= status_next;
            launch_reg <= launch_next;
            bypass_reg <= bypass_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && wr_en) begin
            queue_mem_reg[tail_reg] <= in_reg;
        end
        if (cmd.exec) begin
            rd_entry_reg <= queue_mem_reg[head_reg];
        end
    end

    // identifier packing and data masking for the launched frame
    always_comb begin
        head_ent = bypass_reg ? in_reg : rd_entry_reg;
        if (ext_mode_reg) begin
            b1 = head_ent.id[28:21];
            b2 = head_ent.id[20:13];
            b3 = head_ent.id[12:5];
            b4 = {head_ent.id[4:0], 3'b000};
        end else begin
            b1 = head_ent.id[10:3];
            b2 = {head_ent.id[2:0], 5'b00000};
            b3 = 8'h00;
            b4 = 8'h00;
        end
        for (int i = 0; i < 8; i++) begin
            masked_data[8*i +: 8] = (cantxq_pkg::LEN_W'(i) < head_ent.len) ?
                                    head_ent.data[8*i +: 8] : 8'h00;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_status_reg <= status_reg;
            m_launch_reg <= launch_reg;
            m_b1_reg     <= launch_reg ? b1 : 8'h00;
            m_b2_reg     <= launch_reg ? b2 : 8'h00;
            m_b3_reg     <= launch_reg ? b3 : 8'h00;
            m_b4_reg     <= launch_reg ? b4 : 8'h00;
            m_len_reg    <= launch_reg ? head_ent.len : '0;
            m_data_reg   <= launch_reg ? masked_data : '0;
            m_busy_reg   <= sending_reg;
        end
    end

    assign stat.out_free = !m_valid_reg || m_ready;

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_launch    = m_launch_reg;
    assign m_id_byte1  = m_b1_reg;
    assign m_id_byte2  = m_b2_reg;
    assign m_id_byte3  = m_b3_reg;
    assign m_id_byte4  = m_b4_reg;
    assign m_tx_length = m_len_reg;
    assign m_tx_data   = m_data_reg;
    assign m_busy_res  = m_busy_reg;

endmodule

`default_nettype wire

// File: sv/can_tx_message_queue.sv
// CAN transmit message queue, top level.
// Uses cantxq_pkg, cantxq_ctrl and cantxq_dp.
//
// Channels: s_* carries one request beat (enqueue a frame or a
// transmit-complete event); m_* returns exactly one result beat per
// request. cfg_* writes the identifier mode bit (0 = 11-bit, 1 = 29-bit)
// and is always ready; write it only while no request is in flight.
// One request is handled at a time: the sequencer runs capture,
// execute (ring update, memory write and head read) and load, and
// the load step puts the result in the output register.
// The next request is accepted while the last result still waits.
// A stalled receiver holds the result in the output register; the
// sequencer then waits in its load step and takes no new request.
// Reset (aresetn low, synchronous) empties the queue, clears the busy
// flag, selects 11-bit identifiers and drops any pending result.
// Frame memory contents are not cleared; only entries between head and
// tail are ever read.
`timescale 1ns / 1ps
`default_nettype none

module can_tx_message_queue #(
    parameter int QUEUE_DEPTH = cantxq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire                                  cfg_data,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire                                  s_req_type,
    input  wire [cantxq_pkg::ID_W-1:0]           s_frame_id,
    input  wire [cantxq_pkg::LEN_W-1:0]          s_frame_length,
    input  wire [cantxq_pkg::DATA_W-1:0]         s_frame_data,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic [1:0]                           m_status,
    output logic                                 m_launch,
    output logic [7:0]                           m_id_byte1,
    output logic [7:0]                           m_id_byte2,
    output logic [7:0]                           m_id_byte3,
    output logic [7:0]                           m_id_byte4,
    output logic [cantxq_pkg::LEN_W-1:0]         m_tx_length,
    output logic [cantxq_pkg::DATA_W-1:0]        m_tx_data,
    output logic                                 m_busy_res
);

    cantxq_pkg::dp_cmd_t  cmd;
    cantxq_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    cantxq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cantxq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_data       (cfg_data),
        .s_req_type     (s_req_type),
        .s_frame_id     (s_frame_id),
        .s_frame_length (s_frame_length),
        .s_frame_data   (s_frame_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_launch       (m_launch),
        .m_id_byte1     (m_id_byte1),
        .m_id_byte2     (m_id_byte2),
        .m_id_byte3     (m_id_byte3),
        .m_id_byte4     (m_id_byte4),
        .m_tx_length    (m_tx_length),
        .m_tx_data      (m_tx_data),
        .m_busy_res     (m_busy_res)
    );

endmodule

`default_nettype wire

// File: sv/cantxq_chk.sv
// Port-level checks for the CAN transmit message queue, bound to the top.
// Depends on cantxq_pkg and can_tx_message_queue.
`timescale 1ns / 1ps
`default_nettype none

module cantxq_chk (
    input wire                                 aclk,
    input wire                                 aresetn,
    input wire                                 m_valid,
    input wire                                 m_ready,
    input wire [1:0]                           m_status,
    input wire                                 m_launch,
    input wire [7:0]                           m_id_byte1,
    input wire [7:0]                           m_id_byte2,
    input wire [7:0]                           m_id_byte3,
    input wire [7:0]                           m_id_byte4,
    input wire [cantxq_pkg::LEN_W-1:0]         m_tx_length,
    input wire [cantxq_pkg::DATA_W-1:0]        m_tx_data,
    input wire                                 m_busy_res
);

    // a result beat is not dropped before it is taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    // no launch means an all-zero frame
    a_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_launch |-> m_id_byte1 == 8'h00 && m_id_byte2 == 8'h00 &&
            m_id_byte3 == 8'h00 && m_id_byte4 == 8'h00 &&
            m_tx_length == '0 && m_tx_data == '0)
        else $error("frame fields set without launch");

    // a rejected enqueue never launches
    a_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != cantxq_pkg::ST_OK |-> !m_launch)
        else $error("launch on rejected request");

    // a launch leaves the block busy with a legal length
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_launch |-> m_busy_res && m_tx_length <= cantxq_pkg::MAX_LEN)
        else $error("bad busy flag or length on launch");

endmodule

bind can_tx_message_queue cantxq_chk u_cantxq_chk (.*);

`default_nettype wire

// File: sim/tb_top.sv
// Testbench for can_tx_message_queue: a directed table, then random phases in both id modes.
// Depends on cantxq_pkg and the block RTL; keeps its own copy of the queue and mailbox state.
`timescale 1ns / 1ps

module tb_top;
    import cantxq_pkg::*;

    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int PHASE_ITEMS = 240;
    localparam int NUM_PHASES  = 5;
    localparam int HOLD_AFTER  = 400;
    localparam int HOLD_CYCLES = 250;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 8;
    localparam int MAX_REPORTS = 40;

    localparam logic [ID_W-1:0]   ID_ONES   = '1;
    localparam logic [DATA_W-1:0] DATA_ONES = '1;

    typedef struct {
        status_t           status;
        logic              launch;
        logic [7:0]        id_b1;
        logic [7:0]        id_b2;
        logic [7:0]        id_b3;
        logic [7:0]        id_b4;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
        logic              busy;
    } mbox_beat_t;

    typedef struct {
        logic              req;
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
        bit                fixed;
        mbox_beat_t        want;
    } req_row_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_data;
    logic              s_valid;
    logic              s_ready;
    logic              s_req_type;
    logic [ID_W-1:0]   s_frame_id;
    logic [LEN_W-1:0]  s_frame_length;
    logic [DATA_W-1:0] s_frame_data;
    logic              m_valid;
    logic              m_ready;
    logic [1:0]        m_status;
    logic              m_launch;
    logic [7:0]        m_id_byte1;
    logic [7:0]        m_id_byte2;
    logic [7:0]        m_id_byte3;
    logic [7:0]        m_id_byte4;
    logic [LEN_W-1:0]  m_tx_length;
    logic [DATA_W-1:0] m_tx_data;
    logic              m_busy_res;

    // typed expectation riding along with the current request beat
    bit         s_fixed;
    mbox_beat_t s_want;

    // predicted queue state
    logic [ID_W-1:0]   id_mem   [DEPTH];
    logic [LEN_W-1:0]  len_mem  [DEPTH];
    logic [DATA_W-1:0] data_mem [DEPTH];
    int head = 0;
    int tail = 0;
    bit wrap = 0;
    bit sending = 0;
    bit ext_mode = 0;

    mbox_beat_t mailbox_due[$];
    req_row_t   directed_rows[$];

    int  fails = 0;
    int  beats_seen = 0;
    int  quiet_cycles = 0;
    bit  calm = 0;

    can_tx_message_queue dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_frame_id     (s_frame_id),
        .s_frame_length (s_frame_length),
        .s_frame_data   (s_frame_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_launch       (m_launch),
        .m_id_byte1     (m_id_byte1),
        .m_id_byte2     (m_id_byte2),
        .m_id_byte3     (m_id_byte3),
        .m_id_byte4     (m_id_byte4),
        .m_tx_length    (m_tx_length),
        .m_tx_data      (m_tx_data),
        .m_busy_res     (m_busy_res)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic mbox_beat_t quiet_beat(status_t st, logic busy);
        mbox_beat_t b;
        b.status = st;
        b.launch = 1'b0;
        b.id_b1  = '0;
        b.id_b2  = '0;
        b.id_b3  = '0;
        b.id_b4  = '0;
        b.len    = '0;
        b.data   = '0;
        b.busy   = busy;
        return b;
    endfunction

    // pop the head frame into the mailbox and pack its identifier
    function automatic void hand_over(inout mbox_beat_t b);
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  n;
        logic [DATA_W-1:0] d;
        id = id_mem[head];
        n  = len_mem[head];
        d  = data_mem[head];
        if (ext_mode) begin
            b.id_b1 = id[28:21];
            b.id_b2 = id[20:13];
            b.id_b3 = id[12:5];
            b.id_b4 = {id[4:0], 3'b000};
        end else begin
            b.id_b1 = id[10:3];
            b.id_b2 = {id[2:0], 5'b00000};
            b.id_b3 = '0;
            b.id_b4 = '0;
        end
        // bytes at or past the length read as zero
        if (n < MAX_LEN)
            d &= (64'd1 << {n, 3'b000}) - 64'd1;
        b.launch = 1'b1;
        b.len    = n;
        b.data   = d;
        head = (head + 1) % DEPTH;
        if (head == 0)
            wrap = 1'b0;
        sending = 1'b1;
    endfunction

    function automatic mbox_beat_t mailbox_step(logic req, logic [ID_W-1:0] id,
                                                logic [LEN_W-1:0] len, logic [DATA_W-1:0] data);
        mbox_beat_t b;
        b = quiet_beat(ST_OK, 1'b0);
        if (req == REQ_ENQUEUE) begin
            if (head == tail && wrap) begin
                b.status = ST_FULL;
            end else if (len > MAX_LEN) begin
                b.status = ST_BADLEN;
            end else begin
                id_mem[tail]   = id;
                len_mem[tail]  = len;
                data_mem[tail] = data;
                tail = (tail + 1) % DEPTH;
                if (tail == 0)
                    wrap = 1'b1;
                if (!sending)
                    hand_over(b);
            end
        end else if (head == tail && !wrap) begin
            sending = 1'b0;
        end else begin
            hand_over(b);
        end
        b.busy = sending;
        return b;
    endfunction

    task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            if (fails < MAX_REPORTS)
                $display("%0t ns %s: expected %0h, got %0h", $time, what, want, got);
            fails++;
        end
    endtask

    // predict on every accepted request beat, check every accepted result beat
    always @(posedge aclk) begin : scoreboard
        mbox_beat_t b;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                ext_mode = cfg_data;
            if (s_valid && s_ready) begin
                b = mailbox_step(s_req_type, s_frame_id, s_frame_length, s_frame_data);
                mailbox_due.push_back(s_fixed ? s_want : b);
            end
            if (m_valid && m_ready) begin
                beats_seen++;
                if (mailbox_due.size() == 0) begin
                    if (fails < MAX_REPORTS)
                        $display("%0t ns result beat with nothing expected", $time);
                    fails++;
                end else begin
                    b = mailbox_due.pop_front();
                    check_field("status",    64'(b.status), 64'(m_status));
                    check_field("launch",    64'(b.launch), 64'(m_launch));
                    check_field("id_byte1",  64'(b.id_b1),  64'(m_id_byte1));
                    check_field("id_byte2",  64'(b.id_b2),  64'(m_id_byte2));
                    check_field("id_byte3",  64'(b.id_b3),  64'(m_id_byte3));
                    check_field("id_byte4",  64'(b.id_b4),  64'(m_id_byte4));
                    check_field("tx_length", 64'(b.len),    64'(m_tx_length));
                    check_field("tx_data",   b.data,        m_tx_data);
                    check_field("busy_res",  64'(b.busy),   64'(m_busy_res));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off so the block backs up
    initial begin : receiver
        int stall_left;
        int gap_pct;
        int mood_left;
        bit held;
        stall_left = 0;
        gap_pct = 0;
        mood_left = 0;
        held = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (mood_left == 0) begin
                mood_left = 50;
                gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 12;
            end
            mood_left--;
            if (!held && beats_seen >= HOLD_AFTER) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (calm) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < gap_pct) begin
                stall_left = $urandom_range(0, 17);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_row(req_row_t r);
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_req_type     <= r.req;
        s_frame_id     <= r.id;
        s_frame_length <= r.len;
        s_frame_data   <= r.data;
        s_fixed        <= r.fixed;
        s_want         <= r.want;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic sender_gap(int pct);
        int n;
        if (!calm && $urandom_range(0, 99) < pct) begin
            n = $urandom_range(1, 18);
            repeat (n) @(negedge aclk) s_valid <= 1'b0;
        end
    endtask

    // drop valid, wait out every pending beat and the pipeline
    task automatic settle();
        @(negedge aclk) s_valid <= 1'b0;
        while (mailbox_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_mode(logic v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk) cfg_valid <= 1'b0;
    endtask

    function automatic void add_row(logic req, logic [ID_W-1:0] id, logic [LEN_W-1:0] len,
                                    logic [DATA_W-1:0] data, bit fixed, mbox_beat_t want);
        req_row_t r;
        r.req   = req;
        r.id    = id;
        r.len   = len;
        r.data  = data;
        r.fixed = fixed;
        r.want  = want;
        directed_rows.push_back(r);
    endfunction

    function automatic req_row_t random_row(int enq_pct);
        req_row_t r;
        r.fixed = 1'b0;
        r.want  = quiet_beat(ST_OK, 1'b0);
        r.req   = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQUEUE : REQ_TX_DONE;
        case ($urandom_range(0, 9))
            0:       r.id = '0;
            1:       r.id = ID_ONES;
            2:       r.id = ID_W'(11'h7FF);
            3:       r.id = ID_W'(1) << $urandom_range(0, ID_W - 1);
            default: r.id = ID_W'($urandom);
        endcase
        if ($urandom_range(0, 99) < 85)
            r.len = LEN_W'($urandom_range(0, 8));
        else
            r.len = LEN_W'($urandom_range(9, 15));
        r.data = {$urandom, $urandom};
        return r;
    endfunction

    initial begin : stimulus
        mbox_beat_t none;
        mbox_beat_t first_launch;
        int k;
        int burst;
        int enq_pct;
        int gap_pct;

        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = 1'b0;
        s_valid        = 1'b0;
        s_req_type     = REQ_ENQUEUE;
        s_frame_id     = '0;
        s_frame_length = '0;
        s_frame_data   = '0;
        s_fixed        = 1'b0;
        s_want         = quiet_beat(ST_OK, 1'b0);

        none = quiet_beat(ST_OK, 1'b0);
        first_launch = quiet_beat(ST_OK, 1'b1);
        first_launch.launch = 1'b1;
        first_launch.id_b1  = 8'hFF;
        first_launch.id_b2  = 8'hE0;
        first_launch.len    = MAX_LEN;
        first_launch.data   = DATA_ONES;

        // 11-bit mode: idle completion, bad length, widest frame, then fill to full
        add_row(REQ_TX_DONE, ID_ONES, 4'd15, DATA_ONES, 1'b1, quiet_beat(ST_OK, 1'b0));
        add_row(REQ_ENQUEUE, ID_ONES, 4'd15, DATA_ONES, 1'b1, quiet_beat(ST_BADLEN, 1'b0));
        add_row(REQ_ENQUEUE, ID_ONES, MAX_LEN, DATA_ONES, 1'b1, first_launch);
        for (k = 0; k < DEPTH; k++)
            add_row(REQ_ENQUEUE, (k == 0) ? '0 : ID_W'(32'h0ACE_1357 * k), LEN_W'(k % 9),
                    (k == 0) ? '0 : {8{8'(k * 37 + 5)}}, 1'b0, none);
        add_row(REQ_ENQUEUE, '0, 4'd0, '0, 1'b1, quiet_beat(ST_FULL, 1'b1));
        // full wins over a bad length
        add_row(REQ_ENQUEUE, ID_ONES, 4'd12, DATA_ONES, 1'b1, quiet_beat(ST_FULL, 1'b1));
        add_row(REQ_TX_DONE, '0, 4'd0, '0, 1'b0, none);
        add_row(REQ_ENQUEUE, 29'h155, 4'd9, DATA_ONES, 1'b1, quiet_beat(ST_BADLEN, 1'b1));
        add_row(REQ_ENQUEUE, 29'h0A5, 4'd4, 64'h0123_4567_89AB_CDEF, 1'b0, none);

        repeat (4) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        write_mode(1'b0);
        foreach (directed_rows[i]) begin
            sender_gap(20);
            send_row(directed_rows[i]);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            write_mode(p[0] ? 1'b0 : 1'b1);
            calm = (p == NUM_PHASES - 1);
            k = 0;
            while (k < PHASE_ITEMS) begin
                burst = $urandom_range(1, 40);
                // fill-heavy, balanced and drain-heavy stretches
                case ($urandom_range(0, 2))
                    0:       enq_pct = 90;
                    1:       enq_pct = 55;
                    default: enq_pct = 15;
                endcase
                gap_pct = ($urandom_range(0, 1) == 0) ? 0 : 25;
                repeat (burst) begin
                    sender_gap(gap_pct);
                    send_row(random_row(enq_pct));
                    k++;
                end
            end
        end

        settle();
        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
sv/cantxq_pkg.sv
sv/cantxq_ctrl.sv
sv/cantxq_dp.sv
sv/can_tx_message_queue.sv
sv/cantxq_chk.sv
sim/tb_top.sv
